// ===== sv/saks_pkg.sv =====
// Shared constants, codes and word types for the sorted append key store.
package saks_pkg;

  // Table geometry
  localparam int CAPACITY   = 1024;
  localparam int KEY_WIDTH  = 32;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [1:0]            mode_t;
  typedef logic [1:0]            status_t;
  typedef logic [KEY_WIDTH-1:0]  key_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Operation codes
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  // Result status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_ORDER = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;
  localparam status_t STAT_MISS  = 2'd3;

  // Reserved key value and table size as a count
  localparam key_t KEY_INVALID = {KEY_WIDTH{1'b1}};
  localparam cnt_t CAP_CNT     = CNT_W'(CAPACITY);

  // Input word
  typedef struct packed {
    mode_t mode;
    key_t  key;
    data_t data_in;
  } in_word_t;

  // Result word
  typedef struct packed {
    status_t status;
    data_t   data_out;
  } out_word_t;

  // Access request from control to the store
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_key_en;
    logic  wr_pay_en;
    idx_t  wr_addr;
    logic  wr_present;
    key_t  wr_key;
    data_t wr_data;
  } mem_req_t;

  // Registered read data from the store
  typedef struct packed {
    logic  present;
    key_t  key;
    data_t data;
  } mem_rsp_t;

endpackage

// ===== sv/saks_store.sv =====
// Key/present memory and payload memory, one read and one write port each.
module saks_store import saks_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [KEY_WIDTH:0]    key_mem [CAPACITY];
  data_t                 pay_mem [CAPACITY];
  logic [KEY_WIDTH:0]    key_rd_r;
  data_t                 pay_rd_r;

  // Write key with its present mark
  always_ff @(posedge clk) begin
    if (req.wr_key_en) begin
      key_mem[req.wr_addr] <= {req.wr_present, req.wr_key};
    end
  end

  // Write payload
  always_ff @(posedge clk) begin
    if (req.wr_pay_en) begin
      pay_mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read both memories at the same address
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      key_rd_r <= key_mem[req.rd_addr];
      pay_rd_r <= pay_mem[req.rd_addr];
    end
  end

  assign rsp.present = key_rd_r[KEY_WIDTH];
  assign rsp.key     = key_rd_r[KEY_WIDTH-1:0];
  assign rsp.data    = pay_rd_r;

endmodule

// ===== sv/saks_ctrl.sv =====
// Sequencer: insert append, binary search probe loop, delete mark update.
module saks_ctrl import saks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      resp_valid,
  input  logic      resp_ready,
  output out_word_t resp_word,
  output mem_req_t  req,
  input  mem_rsp_t  rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  key_t       key_r, key_nxt;
  data_t      data_r, data_nxt;
  cnt_t       cnt_r, cnt_nxt;
  key_t       last_key_r, last_key_nxt;
  cnt_t       lo_r, lo_nxt;
  cnt_t       hi_r, hi_nxt;
  cnt_t       mid_r, mid_nxt;
  status_t    status_r, status_nxt;
  data_t      dout_r, dout_nxt;
  logic [CNT_W:0] mid_sum;

  // Next state and memory access
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    data_nxt     = data_r;
    cnt_nxt      = cnt_r;
    last_key_nxt = last_key_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    status_nxt   = status_r;
    dout_nxt     = dout_r;
    mid_sum      = '0;
    in_ready     = 1'b0;
    resp_valid   = 1'b0;
    req          = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt  = in_word.mode;
          key_nxt   = in_word.key;
          data_nxt  = in_word.data_in;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        dout_nxt = '0;
        unique case (mode_r)
          MODE_INSERT: begin
            state_nxt = S_RESP;
            if (key_r == KEY_INVALID || (cnt_r != '0 && key_r <= last_key_r)) begin
              status_nxt = STAT_ORDER;
            end else if (cnt_r >= CAP_CNT) begin
              status_nxt = STAT_FULL;
            end else begin
              req.wr_key_en  = 1'b1;
              req.wr_pay_en  = 1'b1;
              req.wr_addr    = cnt_r[IDX_W-1:0];
              req.wr_present = 1'b1;
              req.wr_key     = key_r;
              req.wr_data    = data_r;
              cnt_nxt        = cnt_r + cnt_t'(1);
              last_key_nxt   = key_r;
              status_nxt     = STAT_OK;
            end
          end
          MODE_SEARCH, MODE_DELETE: begin
            if (key_r == KEY_INVALID || cnt_r == '0) begin
              status_nxt = STAT_MISS;
              state_nxt  = S_RESP;
            end else begin
              lo_nxt      = '0;
              hi_nxt      = cnt_r;
              mid_sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};
              mid_nxt     = mid_sum[CNT_W:1];
              req.rd_en   = 1'b1;
              req.rd_addr = mid_nxt[IDX_W-1:0];
              state_nxt   = S_SEARCH;
            end
          end
          default: begin
            status_nxt = STAT_MISS;
            state_nxt  = S_RESP;
          end
        endcase
      end

      S_SEARCH: begin
        // Compare the probed key, then narrow and issue the next probe
        if (rsp.key == key_r) begin
          state_nxt = S_RESP;
          if (rsp.present) begin
            status_nxt = STAT_OK;
            if (mode_r == MODE_SEARCH) begin
              dout_nxt = rsp.data;
            end else begin
              req.wr_key_en  = 1'b1;
              req.wr_addr    = mid_r[IDX_W-1:0];
              req.wr_present = 1'b0;
              req.wr_key     = key_r;
            end
          end else begin
            status_nxt = STAT_MISS;
          end
        end else begin
          if (key_r < rsp.key) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + cnt_t'(1);
          end
          mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
          if (lo_nxt < hi_nxt) begin
            mid_nxt     = mid_sum[CNT_W:1];
            req.rd_en   = 1'b1;
            req.rd_addr = mid_nxt[IDX_W-1:0];
          end else begin
            status_nxt = STAT_MISS;
            state_nxt  = S_RESP;
          end
        end
      end

      S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign resp_word.status   = status_r;
  assign resp_word.data_out = dout_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      last_key_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      last_key_r <= last_key_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    data_r   <= data_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    status_r <= status_nxt;
    dout_r   <= dout_nxt;
  end

endmodule

// ===== sv/sorted_append_key_store_unit.sv =====
// Top level of the sorted append key store: sequencer, memories and output register.
// Keyed table of up to 1024 records whose keys must be inserted in strictly
// rising order. One word is handled at a time: an insert, an unused mode or a
// reserved key passes from acceptance through the decide and response states to a
// result in the output register; a search or delete also passes through the search
// state once per binary-search probe, at most 11 probes for a full table. The probe
// loop is bound by the key memory's single read port, one probe per cycle with the
// compare done on the registered read data. A new word is accepted as soon as the
// previous result has moved into the output register, even if it is not yet taken.
module sorted_append_key_store_unit import saks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      resp_valid;
  logic      resp_ready;
  out_word_t resp_word;
  mem_req_t  req;
  mem_rsp_t  rsp;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  saks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp_word  (resp_word),
    .req        (req),
    .rsp        (rsp)
  );

  saks_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Load the output register when it is empty or being drained
  assign resp_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (resp_valid && resp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_word_r <= resp_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
